// File: design/fixed_length_frame_receiver_hex_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the fixed-length frame receiver
// Concurrent checks clocked on clk, held off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef FIXED_LENGTH_FRAME_RECEIVER_HEX_MACROS_SVH
`define FIXED_LENGTH_FRAME_RECEIVER_HEX_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define FLFR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("flfr: same-cycle check failed");
// implication starting in the next cycle
`define FLFR_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> cons) \
    else $error("flfr: next-cycle check failed");
`else
`define FLFR_ASSERT_IMP(lbl, ante, cons)
`define FLFR_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// File: design/flfr_pkg.sv
// ----------------------------------------------------------------------------
// flfr_pkg
// Constants and types for the fixed-length frame receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package flfr_pkg;

  localparam int FRAME_LENGTH  = 32;
  localparam int MAX_HEX_BYTES = 32;
  localparam int RESULT_CAP    = 32;

  // results per completed frame
  localparam int NUM_RESULTS_A = (MAX_HEX_BYTES < FRAME_LENGTH) ? MAX_HEX_BYTES : FRAME_LENGTH;
  localparam int NUM_RESULTS   = (NUM_RESULTS_A < RESULT_CAP) ? NUM_RESULTS_A : RESULT_CAP;

  localparam int IDX_W = $clog2(FRAME_LENGTH);

  localparam logic [7:0] START_BYTE = 8'hAA;
  localparam logic [7:0] END_BYTE   = 8'h55;
  localparam logic [7:0] MARK_BYTE  = 8'hFF;

  localparam logic [IDX_W-1:0] LAST_POS   = IDX_W'(FRAME_LENGTH - 1);
  localparam logic [IDX_W-1:0] LAST_RES   = IDX_W'(NUM_RESULTS - 1);
  localparam logic [IDX_W-1:0] CMD_POS    = IDX_W'(2);
  localparam logic [IDX_W-1:0] STATUS_POS = IDX_W'(3);

  localparam logic [1:0] KIND_NONE    = 2'd0;
  localparam logic [1:0] KIND_COMMAND = 2'd1;
  localparam logic [1:0] KIND_STATUS  = 2'd2;

  typedef enum logic [2:0] {
    ST_RECV,
    ST_READ,
    ST_HI,
    ST_LO,
    ST_SEND
  } flfr_state_t;

endpackage

`default_nettype wire

// File: design/flfr_if.sv
// ----------------------------------------------------------------------------
// flfr channels
// Valid/ready channels for received bytes and rendered frame results.
// ----------------------------------------------------------------------------
`default_nettype none

interface flfr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface flfr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic [6:0] hex_high;
  logic [6:0] hex_low;
  logic [4:0] byte_index;
  logic [1:0] frame_kind;
  logic       last;

  modport source (output valid, output frame_byte, output hex_high, output hex_low,
                  output byte_index, output frame_kind, output last, input ready);
  modport sink   (input valid, input frame_byte, input hex_high, input hex_low,
                  input byte_index, input frame_kind, input last, output ready);
endinterface

`default_nettype wire

// File: design/fixed_length_frame_receiver_hex.sv
// ----------------------------------------------------------------------------
// fixed_length_frame_receiver_hex
// Start/end byte deframer for 32-byte frames with ASCII hex rendering.
// ----------------------------------------------------------------------------
// Receiving, the block takes one byte per cycle. A frame opens on 0xAA, holds
// 32 bytes and must close on 0x55; a bad end byte drops the frame silently.
// After a good frame the block stops taking bytes and plays the frame back
// from its 32-entry byte memory, one result per stored byte. Each result passes
// through a memory read, then one shared nibble-to-ASCII converter used twice
// (upper, then lower digit), then the held output transfer, which may stall.
// Bytes are taken again on the cycle following the last transfer of a frame.
`default_nettype none
`include "fixed_length_frame_receiver_hex_macros.svh"

module fixed_length_frame_receiver_hex (
  input  wire           clk,
  input  wire           rst_n,
  flfr_in_if.sink       in_ch,
  flfr_out_if.source    out_ch
);

  flfr_pkg::flfr_state_t state_r, state_nxt;

  logic                      in_frame_r, in_frame_nxt;
  logic [flfr_pkg::IDX_W-1:0] byte_count_r, byte_count_nxt;
  logic [flfr_pkg::IDX_W-1:0] emit_idx_r, emit_idx_nxt;
  logic                      cmd_r, status_r;

  logic [7:0] frame_mem [flfr_pkg::FRAME_LENGTH];
  logic [7:0] rd_data_r;
  logic [6:0] hex_high_r, hex_low_r;

  logic                       in_xfer, out_xfer;
  logic                       mem_we;
  logic [flfr_pkg::IDX_W-1:0] mem_waddr;
  logic                       frame_done;

  logic [3:0] conv_nib;
  logic [6:0] conv_ascii;

  assign in_xfer  = in_ch.valid && in_ch.ready;
  assign out_xfer = out_ch.valid && out_ch.ready;

  assign in_ch.ready  = (state_r == flfr_pkg::ST_RECV);
  assign out_ch.valid = (state_r == flfr_pkg::ST_SEND);

  // shared nibble converter: upper digit in ST_HI, lower digit otherwise
  assign conv_nib   = (state_r == flfr_pkg::ST_HI) ? rd_data_r[7:4] : rd_data_r[3:0];
  assign conv_ascii = (conv_nib < 4'hA) ? (7'h30 + {3'b000, conv_nib})
                                        : (7'h37 + {3'b000, conv_nib});

  // byte intake: address, write enable and framing decisions
  always_comb begin
    in_frame_nxt   = in_frame_r;
    byte_count_nxt = byte_count_r;
    mem_we         = 1'b0;
    mem_waddr      = byte_count_r;
    frame_done     = 1'b0;
    if (in_xfer) begin
      if (in_frame_r) begin
        if (byte_count_r < flfr_pkg::LAST_POS) begin
          mem_we         = 1'b1;
          byte_count_nxt = byte_count_r + 1'b1;
        end else begin
          in_frame_nxt   = 1'b0;
          byte_count_nxt = '0;
          if (in_ch.rx_byte == flfr_pkg::END_BYTE) begin
            mem_we     = 1'b1;
            mem_waddr  = flfr_pkg::LAST_POS;
            frame_done = 1'b1;
          end
        end
      end else if (in_ch.rx_byte == flfr_pkg::START_BYTE) begin
        in_frame_nxt   = 1'b1;
        mem_we         = 1'b1;
        mem_waddr      = '0;
        byte_count_nxt = {{(flfr_pkg::IDX_W-1){1'b0}}, 1'b1};
      end else begin
        byte_count_nxt = '0;
      end
    end
  end

  // playback sequencer
  always_comb begin
    state_nxt    = state_r;
    emit_idx_nxt = emit_idx_r;
    unique case (state_r)
      flfr_pkg::ST_RECV: begin
        if (frame_done) begin
          state_nxt    = flfr_pkg::ST_READ;
          emit_idx_nxt = '0;
        end
      end
      flfr_pkg::ST_READ: state_nxt = flfr_pkg::ST_HI;
      flfr_pkg::ST_HI:   state_nxt = flfr_pkg::ST_LO;
      flfr_pkg::ST_LO:   state_nxt = flfr_pkg::ST_SEND;
      flfr_pkg::ST_SEND: begin
        if (out_xfer) begin
          if (emit_idx_r == flfr_pkg::LAST_RES) begin
            state_nxt = flfr_pkg::ST_RECV;
          end else begin
            state_nxt    = flfr_pkg::ST_READ;
            emit_idx_nxt = emit_idx_r + 1'b1;
          end
        end
      end
      default: state_nxt = flfr_pkg::ST_RECV;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= flfr_pkg::ST_RECV;
      in_frame_r   <= 1'b0;
      byte_count_r <= '0;
      emit_idx_r   <= '0;
    end else begin
      state_r      <= state_nxt;
      in_frame_r   <= in_frame_nxt;
      byte_count_r <= byte_count_nxt;
      emit_idx_r   <= emit_idx_nxt;
    end
  end

  // frame memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      frame_mem[mem_waddr] <= in_ch.rx_byte;
    end
    if (state_r == flfr_pkg::ST_READ) begin
      rd_data_r <= frame_mem[emit_idx_r];
    end
  end

  // kind flags follow the writes to positions 2 and 3; hex digits are captured in ST_HI and ST_LO
  always_ff @(posedge clk) begin
    if (mem_we && mem_waddr == flfr_pkg::CMD_POS) begin
      cmd_r <= (in_ch.rx_byte == flfr_pkg::MARK_BYTE);
    end
    if (mem_we && mem_waddr == flfr_pkg::STATUS_POS) begin
      status_r <= (in_ch.rx_byte == flfr_pkg::MARK_BYTE);
    end
    if (state_r == flfr_pkg::ST_HI) begin
      hex_high_r <= conv_ascii;
    end
    if (state_r == flfr_pkg::ST_LO) begin
      hex_low_r <= conv_ascii;
    end
  end

  assign out_ch.frame_byte = rd_data_r;
  assign out_ch.hex_high   = hex_high_r;
  assign out_ch.hex_low    = hex_low_r;
  assign out_ch.byte_index = 5'(emit_idx_r);
  assign out_ch.frame_kind = status_r ? flfr_pkg::KIND_STATUS :
                             (cmd_r ? flfr_pkg::KIND_COMMAND : flfr_pkg::KIND_NONE);
  assign out_ch.last       = (emit_idx_r == flfr_pkg::LAST_RES);

  `FLFR_ASSERT_IMP(a_no_overlap, in_ch.ready, !out_ch.valid)
  `FLFR_ASSERT_NXT(a_last_frees_input, out_xfer && out_ch.last, in_ch.ready)
  `FLFR_ASSERT_NXT(a_frame_emits, frame_done, ##3 out_ch.valid)
  `FLFR_ASSERT_IMP(a_first_is_start, out_ch.valid && out_ch.byte_index == 5'd0,
                   out_ch.frame_byte == flfr_pkg::START_BYTE)

endmodule

`default_nettype wire
